// ----- rtl/bb3_pkg.sv -----
// Package for the 3x3 box blur: sizes, register codes and shared types.
// Used by the channel interfaces, the line buffer, the divider and the top level.
`default_nettype none

package bb3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int WIDTH_RESET     = 640;
   localparam int HEIGHT_RESET    = 480;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int CH_W   = 8;
   localparam int PIX_W  = 3 * CH_W;
   localparam int LINE_W = 2 * PIX_W;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W   = $clog2(MAX_HEIGHT);
   localparam int IROW_W   = $clog2(MAX_HEIGHT + 2);

   localparam int WIN_N   = 9;
   localparam int CNT_W   = $clog2(WIN_N + 1);
   localparam int SUM_W   = $clog2(WIN_N * ((1 << CH_W) - 1) + 1);
   localparam int NUM_W   = SUM_W + 1;
   localparam int DIV_W   = CNT_W + 1;
   localparam int QSTEP_W = $clog2(CH_W);

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic                      start;
      logic [2:0][SUM_W-1:0]     sum;
      logic [CNT_W-1:0]          count;
   } div_cmd_type;

   typedef struct packed {
      logic      busy;
      logic      done;
      pixel_type quot;
   } div_res_type;

endpackage

`default_nettype wire

// ----- rtl/bb3_ifs.sv -----
// Valid/ready channel interfaces for the box blur: pixel request, result, register write.
// Depends on bb3_pkg for field widths.
`default_nettype none

interface bb3_req_if;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [bb3_pkg::CH_W-1:0] in_red;
   logic [bb3_pkg::CH_W-1:0] in_green;
   logic [bb3_pkg::CH_W-1:0] in_blue;

   modport source (output valid, mode, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [bb3_pkg::CH_W-1:0] out_red;
   logic [bb3_pkg::CH_W-1:0] out_green;
   logic [bb3_pkg::CH_W-1:0] out_blue;
   logic                     frame_end;

   modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface bb3_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bb3_pkg::CSR_IDX_W-1:0]  index;
   logic [bb3_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bb3_line_buf.sv -----
// Line buffer RAM: older and middle row side by side, one entry per column.
// One write and one registered read per cycle; depends on bb3_pkg.
`default_nettype none

module bb3_line_buf (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [bb3_pkg::COL_W-1:0]  rd_addr,
   output logic      [bb3_pkg::LINE_W-1:0] rd_data,
   input  wire logic                       wr_en,
   input  wire logic [bb3_pkg::COL_W-1:0]  wr_addr,
   input  wire logic [bb3_pkg::LINE_W-1:0] wr_data
);

   logic [bb3_pkg::LINE_W-1:0] mem_ff [bb3_pkg::MAX_WIDTH];
   logic [bb3_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/bb3_divider.sv -----
// Rounded mean divider for three channels: (2*sum+count)/(2*count), one quotient bit a cycle.
// Depends on bb3_pkg for the command and result structs.
`default_nettype none

module bb3_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bb3_pkg::div_cmd_type cmd,
   output bb3_pkg::div_res_type      res
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [bb3_pkg::QSTEP_W-1:0]            step_ff, step_in;
   logic [bb3_pkg::DIV_W-1:0]              dvs_ff, dvs_in;
   logic [2:0][bb3_pkg::NUM_W-1:0]         rem_ff, rem_in;
   logic [2:0][bb3_pkg::CH_W-1:0]          quo_ff, quo_in;
   logic [bb3_pkg::NUM_W-1:0]              trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = bb3_pkg::NUM_W'(dvs_ff) << step_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = bb3_pkg::QSTEP_W'(bb3_pkg::CH_W - 1);
         dvs_in  = {cmd.count, 1'b0};
         for (int ch = 0; ch < 3; ch++) begin
            rem_in[ch] = {cmd.sum[ch], 1'b0} + bb3_pkg::NUM_W'(cmd.count);
            quo_in[ch] = '0;
         end
      end else if (busy_ff) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (rem_ff[ch] >= trial) begin
               rem_in[ch]          = rem_ff[ch] - trial;
               quo_in[ch][step_ff] = 1'b1;
            end
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign res.busy       = busy_ff;
   assign res.done       = done_ff;
   assign res.quot.red   = quo_ff[0];
   assign res.quot.green = quo_ff[1];
   assign res.quot.blue  = quo_ff[2];

endmodule

`default_nettype wire

// ----- rtl/box_blur_three_by_three.sv -----
// Top level of the 3x3 box blur over a raster RGB pixel stream.
// Depends on bb3_pkg, bb3_ifs, bb3_line_buf and bb3_divider.
//
// Pixels enter in raster order; the result for pixel k leaves with input word k+width+1,
// so after a frame the host sends width+1 drain words (mode 1) to flush it. Each output
// channel is the half-up rounded mean of the in-frame pixels of its 3x3 neighborhood.
// A result word goes through accept, line buffer read and window shift, sum, divider load,
// eight divider steps plus handoff, and the move into the output register, which waits
// while that register holds an untaken result; the divider yields one quotient bit per
// cycle. A no-result word is only accepted and read; a mid-frame drain word only accepted.
// A finished word waits in the output register while the next input word is accepted.
// The line buffers need no clearing after reset: an entry read before it is written only
// feeds neighbors outside the frame, which the mean leaves out.
// Writing either register restarts the frame.
`default_nettype none

module box_blur_three_by_three (
   input  wire logic clock,
   input  wire logic reset,
   bb3_req_if.sink   req,
   bb3_rsp_if.source rsp,
   bb3_csr_if.sink   csr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_LOAD,
      ST_DIV,
      ST_PUSH
   } state_type;

   function automatic logic [bb3_pkg::WIDTH_W-1:0] clamp_width(
      input logic [bb3_pkg::CFG_WIDTH_BITS-1:0] raw
   );
      logic [bb3_pkg::WIDTH_W-1:0] eff;
      if (raw == '0) begin
         eff = bb3_pkg::WIDTH_W'(1);
      end else if (int'(raw) > bb3_pkg::MAX_WIDTH) begin
         eff = bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH);
      end else begin
         eff = bb3_pkg::WIDTH_W'(raw);
      end
      return eff;
   endfunction

   function automatic logic [bb3_pkg::HEIGHT_W-1:0] clamp_height(
      input logic [bb3_pkg::CFG_HEIGHT_BITS-1:0] raw
   );
      logic [bb3_pkg::HEIGHT_W-1:0] eff;
      if (raw == '0) begin
         eff = bb3_pkg::HEIGHT_W'(1);
      end else if (int'(raw) > bb3_pkg::MAX_HEIGHT) begin
         eff = bb3_pkg::HEIGHT_W'(bb3_pkg::MAX_HEIGHT);
      end else begin
         eff = bb3_pkg::HEIGHT_W'(raw);
      end
      return eff;
   endfunction

   state_type                        state_ff, state_in;
   logic [bb3_pkg::WIDTH_W-1:0]      width_ff, width_in;
   logic [bb3_pkg::HEIGHT_W-1:0]     height_ff, height_in;
   logic [bb3_pkg::COL_W-1:0]        icol_ff, icol_in;
   logic [bb3_pkg::IROW_W-1:0]       irow_ff, irow_in;
   logic [bb3_pkg::COL_W-1:0]        ocol_ff, ocol_in;
   logic [bb3_pkg::OROW_W-1:0]       orow_ff, orow_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   bb3_pkg::pixel_type               pix_ff, pix_in;
   bb3_pkg::pixel_type               win_ff [bb3_pkg::WIN_N];
   bb3_pkg::pixel_type               win_in [bb3_pkg::WIN_N];
   logic [bb3_pkg::WIN_N-1:0]        mask_ff, mask_in;
   logic                             fend_ff, fend_in;
   logic [2:0][bb3_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [bb3_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   bb3_pkg::pixel_type               rsp_pix_ff, rsp_pix_in;
   logic                             rsp_fend_ff, rsp_fend_in;

   logic                             accept;
   logic                             drain;
   logic                             skip;
   logic                             emit;
   logic                             right_edge;
   logic                             col_last;
   logic                             row_last;
   logic                             push_go;
   logic [2:0]                       col_ok;
   logic [2:0]                       row_ok;
   logic                             rd_en;
   logic                             wr_en;
   logic [bb3_pkg::LINE_W-1:0]       rd_data;
   bb3_pkg::pixel_type               up_pix;
   bb3_pkg::pixel_type               mid_pix;
   bb3_pkg::div_cmd_type             div_cmd;
   bb3_pkg::div_res_type             div_res;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign drain      = irow_ff >= bb3_pkg::IROW_W'(height_ff);
   assign skip       = !drain && req.mode;
   assign emit       = (irow_ff >= bb3_pkg::IROW_W'(2)) ||
                       ((irow_ff == bb3_pkg::IROW_W'(1)) && (icol_ff != '0));
   assign right_edge = bb3_pkg::WIDTH_W'(ocol_ff) >= (width_ff - 1'b1);
   assign col_last   = (bb3_pkg::WIDTH_W'(icol_ff) + 1'b1) >= width_ff;
   assign row_last   = (bb3_pkg::HEIGHT_W'(orow_ff) + 1'b1) >= height_ff;
   assign push_go    = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp.ready);

   assign col_ok = {!right_edge, 1'b1, ocol_ff != '0};
   assign row_ok = {!row_last, 1'b1, orow_ff != '0};

   assign up_pix  = rd_data[bb3_pkg::LINE_W-1:bb3_pkg::PIX_W];
   assign mid_pix = rd_data[bb3_pkg::PIX_W-1:0];

   bb3_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (icol_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (icol_ff),
      .wr_data ({mid_pix, pix_ff})
   );

   bb3_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      icol_in      = icol_ff;
      irow_in      = irow_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pix_in       = pix_ff;
      win_in       = win_ff;
      mask_in      = mask_ff;
      fend_in      = fend_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_fend_in  = rsp_fend_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      div_cmd.start = 1'b0;
      div_cmd.sum   = sum_ff;
      div_cmd.count = cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !skip) begin
               rd_en = 1'b1;
               if (drain) begin
                  pix_in = '0;
               end else begin
                  pix_in = {req.in_red, req.in_green, req.in_blue};
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            wr_en = 1'b1;
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]     = win_ff[r*3+1];
               win_in[r*3 + 1] = win_ff[r*3+2];
               for (int c = 0; c < 3; c++) begin
                  mask_in[r*3 + c] = row_ok[r] && col_ok[c];
               end
            end
            win_in[2] = up_pix;
            win_in[5] = mid_pix;
            win_in[8] = pix_ff;
            fend_in   = right_edge && row_last;
            if (col_last) begin
               icol_in = '0;
               irow_in = irow_ff + 1'b1;
            end else begin
               icol_in = icol_ff + 1'b1;
            end
            if (emit) begin
               if (right_edge) begin
                  ocol_in = '0;
                  if (row_last) begin
                     icol_in = '0;
                     irow_in = '0;
                     orow_in = '0;
                  end else begin
                     orow_in = orow_ff + 1'b1;
                  end
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
               state_in = ST_SUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            sum_in = '0;
            for (int i = 0; i < bb3_pkg::WIN_N; i++) begin
               if (mask_ff[i]) begin
                  sum_in[0] = sum_in[0] + bb3_pkg::SUM_W'(win_ff[i].red);
                  sum_in[1] = sum_in[1] + bb3_pkg::SUM_W'(win_ff[i].green);
                  sum_in[2] = sum_in[2] + bb3_pkg::SUM_W'(win_ff[i].blue);
               end
            end
            cnt_in   = bb3_pkg::CNT_W'($countones(mask_ff));
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            div_cmd.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_go) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = div_res.quot;
               rsp_fend_in  = fend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            bb3_pkg::REG_IMAGE_WIDTH: begin
               width_in = clamp_width(csr.data[bb3_pkg::CFG_WIDTH_BITS-1:0]);
               icol_in  = '0;
               irow_in  = '0;
               ocol_in  = '0;
               orow_in  = '0;
            end
            bb3_pkg::REG_IMAGE_HEIGHT: begin
               height_in = clamp_height(csr.data[bb3_pkg::CFG_HEIGHT_BITS-1:0]);
               icol_in   = '0;
               irow_in   = '0;
               ocol_in   = '0;
               orow_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= clamp_width(bb3_pkg::CFG_WIDTH_BITS'(bb3_pkg::WIDTH_RESET));
         height_ff    <= clamp_height(bb3_pkg::CFG_HEIGHT_BITS'(bb3_pkg::HEIGHT_RESET));
         icol_ff      <= '0;
         irow_ff      <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         icol_ff      <= icol_in;
         irow_ff      <= irow_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      win_ff      <= win_in;
      mask_ff     <= mask_in;
      fend_ff     <= fend_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_fend_ff <= rsp_fend_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_red   = rsp_pix_ff.red;
   assign rsp.out_green = rsp_pix_ff.green;
   assign rsp.out_blue  = rsp_pix_ff.blue;
   assign rsp.frame_end = rsp_fend_ff;

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (push_go && fend_ff) |=>
         (icol_ff == '0 && irow_ff == '0 && ocol_ff == '0 && orow_ff == '0))
      else $error("counters not cleared after frame end word");

   a_center_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (mask_ff[4] && cnt_ff != '0))
      else $error("window center missing from mean");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_cols_in_range: assert property (@(posedge clock) disable iff (reset)
      (bb3_pkg::WIDTH_W'(ocol_ff) < width_ff) && (bb3_pkg::WIDTH_W'(icol_ff) < width_ff))
      else $error("column counter beyond row width");

   a_read_before_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(rd_en))
      else $error("line buffer written without preceding read");

endmodule

`default_nettype wire
